// ===== design/bank_mapper_with_rtc_macros.svh =====
// assertion macros shared by the bank mapper
`ifndef BANK_MAPPER_WITH_RTC_MACROS_SVH
`define BANK_MAPPER_WITH_RTC_MACROS_SVH

// property checked on every rising edge outside reset
`define BMR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication form of the above
`define BMR_ASSERT_IMP(name, pre, post, msg) \
  `BMR_ASSERT(name, (pre) |-> (post), msg)

`endif

// ===== design/bmrtc_pkg.sv =====
package bmrtc_pkg;

  localparam int ROM_BANK_COUNT = 128;
  localparam int RAM_BANK_COUNT = 8;

  localparam int ROM_BANK_W = 7;
  localparam int RAM_BANK_W = 3;
  localparam int ROM_OFS_W  = 14;
  localparam int RAM_OFS_W  = 13;
  localparam int ADDR_W     = 21;
  localparam int LATCH_N    = 5;
  localparam int LATCH_IW   = 3;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2,
    TGT_RTC  = 2'd3
  } target_e;

  // bus address regions, by address bits 15:13
  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_ROMBANK = 3'd1;
  localparam logic [2:0] REG_BANKSEL = 3'd2;
  localparam logic [2:0] REG_LATCH   = 3'd3;
  localparam logic [2:0] REG_EXT     = 3'd5;

  // rtc register selects
  localparam logic [3:0] RTC_SEL_SEC  = 4'h8;
  localparam logic [3:0] RTC_SEL_MIN  = 4'h9;
  localparam logic [3:0] RTC_SEL_HOUR = 4'hA;
  localparam logic [3:0] RTC_SEL_DAYL = 4'hB;
  localparam logic [3:0] RTC_SEL_DAYH = 4'hC;

  localparam logic [7:0] ENABLE_MASK  = 8'h0A;
  localparam logic [7:0] RAM_SEL_MAX  = 8'h07;
  localparam logic [7:0] RTC_SEL_MAX  = 8'h0C;
  localparam logic [7:0] LATCH_ARM    = 8'h00;
  localparam logic [7:0] LATCH_FIRE   = 8'h01;
  localparam logic [5:0] SEC_LIMIT    = 6'd60;
  localparam logic [4:0] HOUR_LIMIT   = 5'd24;
  localparam logic [8:0] DAY_MAX      = 9'h1FF;

  typedef logic [ROM_BANK_W-1:0] rom_tbl_t [2**ROM_BANK_W];
  typedef logic [RAM_BANK_W-1:0] ram_tbl_t [2**RAM_BANK_W];

  function automatic rom_tbl_t build_rom_mod();
    rom_tbl_t t;
    for (int i = 0; i < 2**ROM_BANK_W; i++) begin
      t[i] = ROM_BANK_W'(i % ROM_BANK_COUNT);
    end
    return t;
  endfunction

  function automatic ram_tbl_t build_ram_mod();
    ram_tbl_t t;
    for (int i = 0; i < 2**RAM_BANK_W; i++) begin
      t[i] = RAM_BANK_W'(i % RAM_BANK_COUNT);
    end
    return t;
  endfunction

  // bank reduced to the fitted bank count
  localparam rom_tbl_t ROM_MOD_TBL = build_rom_mod();
  localparam ram_tbl_t RAM_MOD_TBL = build_ram_mod();

endpackage

// ===== design/bank_mapper_with_rtc.sv =====
// channel   dir  tuser                 tdata
// s_axis    in   cmd[1:0]              bus_address[15:0], bus_data[23:16]
// m_axis    out  target[1:0]           mem_address[20:0], mem_write[21],
//                                      rtc_data[29:22], accepted[30], zero[31]
//
// one beat in per cycle while not stalled, its result in the next cycle from the output register
// every beat gives exactly one result beat; all state updates on the input beat
// the input stalls only while the output register holds a beat not yet taken
// asynchronous active-low reset clears RAM bank, mode and clock state and sets the ROM bank to 1
module bank_mapper_with_rtc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // bus_address[15:0], bus_data[23:16]
  input  logic [1:0]  s_axis_tuser_i,  // cmd[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // mem_address, mem_write, rtc_data, accepted
  output logic [1:0]  m_axis_tuser_o   // target[1:0]
);

  logic [15:0] addr;
  logic [7:0]  data;
  logic        in_fire;

  assign addr = s_axis_tdata_i[15:0];
  assign data = s_axis_tdata_i[23:16];

  // control and clock state
  logic                             ram_en_q, ram_en_d;
  logic [bmrtc_pkg::ROM_BANK_W-1:0] rom_bank_q, rom_bank_d;
  logic [bmrtc_pkg::RAM_BANK_W-1:0] ram_bank_q, ram_bank_d;
  logic [3:0]                       rtc_sel_q, rtc_sel_d;
  logic                             rtc_mode_q, rtc_mode_d;
  logic [7:0]                       last_latch_q, last_latch_d;
  logic [5:0]                       sec_q, sec_d;
  logic [5:0]                       min_q, min_d;
  logic [4:0]                       hour_q, hour_d;
  logic [8:0]                       day_q, day_d;
  logic                             halt_q, halt_d;
  logic                             carry_q, carry_d;
  logic [7:0]                       latch_q [bmrtc_pkg::LATCH_N];
  logic                             latch_en;

  // result register
  logic                             out_valid_q;
  bmrtc_pkg::target_e               out_tgt_q, res_tgt;
  logic [bmrtc_pkg::ADDR_W-1:0]     out_addr_q, res_addr;
  logic                             out_wr_q, res_wr;
  logic [7:0]                       out_rtc_q, res_rtc;
  logic                             out_ok_q, res_ok;

  logic [5:0]                       sec_inc, min_inc;
  logic [4:0]                       hour_inc;
  logic [bmrtc_pkg::ROM_BANK_W-1:0] rom_mod;
  logic [bmrtc_pkg::RAM_BANK_W-1:0] ram_mod;
  logic [bmrtc_pkg::ADDR_W-1:0]     ram_phys;
  logic [bmrtc_pkg::LATCH_IW-1:0]   rtc_idx;
  logic                             rtc_sel_ok;
  logic [7:0]                       rtc_rd;
  logic [6:0]                       rom_wr_bank;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign rom_mod  = bmrtc_pkg::ROM_MOD_TBL[rom_bank_q];
  assign ram_mod  = bmrtc_pkg::RAM_MOD_TBL[ram_bank_q];
  assign ram_phys = bmrtc_pkg::ADDR_W'({ram_mod, addr[bmrtc_pkg::RAM_OFS_W-1:0]});

  assign sec_inc  = sec_q + 6'd1;
  assign min_inc  = min_q + 6'd1;
  assign hour_inc = hour_q + 5'd1;

  assign rtc_sel_ok = (rtc_sel_q >= bmrtc_pkg::RTC_SEL_SEC) &&
                      (rtc_sel_q <= bmrtc_pkg::RTC_SEL_DAYH);
  assign rtc_idx    = bmrtc_pkg::LATCH_IW'(rtc_sel_q - bmrtc_pkg::RTC_SEL_SEC);
  assign rtc_rd     = rtc_sel_ok ? latch_q[rtc_idx] : 8'h00;
  assign rom_wr_bank = data[6:0];

  always_comb begin
    ram_en_d     = ram_en_q;
    rom_bank_d   = rom_bank_q;
    ram_bank_d   = ram_bank_q;
    rtc_sel_d    = rtc_sel_q;
    rtc_mode_d   = rtc_mode_q;
    last_latch_d = last_latch_q;
    sec_d        = sec_q;
    min_d        = min_q;
    hour_d       = hour_q;
    day_d        = day_q;
    halt_d       = halt_q;
    carry_d      = carry_q;
    latch_en     = 1'b0;
    res_tgt      = bmrtc_pkg::TGT_NONE;
    res_addr     = '0;
    res_wr       = 1'b0;
    res_rtc      = 8'h00;
    res_ok       = 1'b0;

    unique case (s_axis_tuser_i)
      bmrtc_pkg::CMD_TICK: begin
        res_ok = 1'b1;
        if (!halt_q) begin
          sec_d = sec_inc;
          if (sec_inc == bmrtc_pkg::SEC_LIMIT) begin
            sec_d = '0;
            min_d = min_inc;
            if (min_inc == bmrtc_pkg::SEC_LIMIT) begin
              min_d  = '0;
              hour_d = hour_inc;
              if (hour_inc == bmrtc_pkg::HOUR_LIMIT) begin
                hour_d = '0;
                if (day_q == bmrtc_pkg::DAY_MAX) begin
                  day_d   = '0;
                  carry_d = 1'b1;
                end else begin
                  day_d = day_q + 9'd1;
                end
              end
            end
          end
        end
      end

      bmrtc_pkg::CMD_READ: begin
        if (!addr[15]) begin
          res_tgt = bmrtc_pkg::TGT_ROM;
          res_ok  = 1'b1;
          if (!addr[14]) begin
            res_addr = bmrtc_pkg::ADDR_W'(addr);
          end else begin
            res_addr = {rom_mod, addr[bmrtc_pkg::ROM_OFS_W-1:0]};
          end
        end else if (addr[15:13] == bmrtc_pkg::REG_EXT && ram_en_q) begin
          res_ok = 1'b1;
          if (rtc_mode_q) begin
            res_tgt = bmrtc_pkg::TGT_RTC;
            res_rtc = rtc_rd;
          end else begin
            res_tgt  = bmrtc_pkg::TGT_RAM;
            res_addr = ram_phys;
          end
        end
      end

      bmrtc_pkg::CMD_WRITE: begin
        unique case (addr[15:13])
          bmrtc_pkg::REG_ENABLE: begin
            res_ok   = 1'b1;
            ram_en_d = (data & bmrtc_pkg::ENABLE_MASK) == bmrtc_pkg::ENABLE_MASK;
          end
          bmrtc_pkg::REG_ROMBANK: begin
            res_ok     = 1'b1;
            rom_bank_d = (rom_wr_bank == 7'd0) ? 7'd1 : rom_wr_bank;
          end
          bmrtc_pkg::REG_BANKSEL: begin
            if (data <= bmrtc_pkg::RAM_SEL_MAX) begin
              res_ok     = 1'b1;
              ram_bank_d = data[bmrtc_pkg::RAM_BANK_W-1:0];
              rtc_mode_d = 1'b0;
            end else if (data <= bmrtc_pkg::RTC_SEL_MAX) begin
              res_ok     = 1'b1;
              rtc_sel_d  = data[3:0];
              rtc_mode_d = 1'b1;
            end
          end
          bmrtc_pkg::REG_LATCH: begin
            res_ok       = 1'b1;
            latch_en     = (last_latch_q == bmrtc_pkg::LATCH_ARM) &&
                           (data == bmrtc_pkg::LATCH_FIRE);
            last_latch_d = data;
          end
          bmrtc_pkg::REG_EXT: begin
            if (ram_en_q) begin
              res_ok = 1'b1;
              if (rtc_mode_q) begin
                res_tgt = bmrtc_pkg::TGT_RTC;
                // live counter write, masked to its width
                unique case (rtc_sel_q)
                  bmrtc_pkg::RTC_SEL_SEC:  sec_d  = data[5:0];
                  bmrtc_pkg::RTC_SEL_MIN:  min_d  = data[5:0];
                  bmrtc_pkg::RTC_SEL_HOUR: hour_d = data[4:0];
                  bmrtc_pkg::RTC_SEL_DAYL: day_d  = {day_q[8], data};
                  bmrtc_pkg::RTC_SEL_DAYH: begin
                    day_d   = {data[0], day_q[7:0]};
                    halt_d  = data[6];
                    carry_d = data[7];
                  end
                  default: ;
                endcase
              end else begin
                res_tgt  = bmrtc_pkg::TGT_RAM;
                res_addr = ram_phys;
                res_wr   = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_en_q     <= 1'b0;
      rom_bank_q   <= 7'd1;
      ram_bank_q   <= '0;
      rtc_sel_q    <= '0;
      rtc_mode_q   <= 1'b0;
      last_latch_q <= 8'hFF;
      sec_q        <= '0;
      min_q        <= '0;
      hour_q       <= '0;
      day_q        <= '0;
      halt_q       <= 1'b0;
      carry_q      <= 1'b0;
      for (int i = 0; i < bmrtc_pkg::LATCH_N; i++) begin
        latch_q[i] <= 8'h00;
      end
    end else if (in_fire) begin
      ram_en_q     <= ram_en_d;
      rom_bank_q   <= rom_bank_d;
      ram_bank_q   <= ram_bank_d;
      rtc_sel_q    <= rtc_sel_d;
      rtc_mode_q   <= rtc_mode_d;
      last_latch_q <= last_latch_d;
      sec_q        <= sec_d;
      min_q        <= min_d;
      hour_q       <= hour_d;
      day_q        <= day_d;
      halt_q       <= halt_d;
      carry_q      <= carry_d;
      // latch copies the counters as they stand before this beat
      if (latch_en) begin
        latch_q[0] <= 8'(sec_q);
        latch_q[1] <= 8'(min_q);
        latch_q[2] <= 8'(hour_q);
        latch_q[3] <= day_q[7:0];
        latch_q[4] <= {carry_q, halt_q, 5'd0, day_q[8]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_tgt_q  <= res_tgt;
      out_addr_q <= res_addr;
      out_wr_q   <= res_wr;
      out_rtc_q  <= res_rtc;
      out_ok_q   <= res_ok;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_tgt_q;
  assign m_axis_tdata_o  = {1'b0, out_ok_q, out_rtc_q, out_wr_q, out_addr_q};

  `include "bank_mapper_with_rtc_macros.svh"

  `BMR_ASSERT(a_rom_bank_nonzero, rom_bank_q != 7'd0, "rom bank register holds zero")
  `BMR_ASSERT_IMP(a_in_gives_out, in_fire, ##1 m_axis_tvalid_o, "input beat without result beat")
  `BMR_ASSERT_IMP(a_refused_clean, m_axis_tvalid_o && !out_ok_q, m_axis_tdata_o == 32'd0 && out_tgt_q == bmrtc_pkg::TGT_NONE, "refused beat carries data")
  `BMR_ASSERT_IMP(a_write_is_ram, m_axis_tvalid_o && out_wr_q, out_tgt_q == bmrtc_pkg::TGT_RAM && out_ok_q, "ram write without ram target")

endmodule
